// File: rtl/serial_escape_stream_parser_defines.svh
// ----------------------------------------------------------------------------
// Serial escape stream parser: assertion macros
// Shared property macros used by the parser modules.
// ----------------------------------------------------------------------------
`ifndef SERIAL_ESCAPE_STREAM_PARSER_DEFINES_SVH
`define SERIAL_ESCAPE_STREAM_PARSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SESP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SESP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/sesp_pkg.sv
// ----------------------------------------------------------------------------
// Serial escape stream parser package
// Types, escape codes and register indexes shared by the parser modules.
// ----------------------------------------------------------------------------
package sesp_pkg;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_NORMAL  = 2'd0,
    PH_CODE    = 2'd1,
    PH_COLLECT = 2'd2
  } phase_t;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_BREAK = 3'd1,
    KIND_LSR   = 3'd2,
    KIND_MSR   = 3'd3,
    KIND_BAUD  = 3'd4,
    KIND_LCTL  = 3'd5
  } kind_t;

  // Escape sequence codes.
  localparam logic [7:0] CODE_ESC      = 8'd0;
  localparam logic [7:0] CODE_LSR_DATA = 8'd1;
  localparam logic [7:0] CODE_LSR_ONLY = 8'd2;
  localparam logic [7:0] CODE_MST      = 8'd3;
  localparam logic [7:0] CODE_BAUD     = 8'd16;
  localparam logic [7:0] CODE_LCTL     = 8'd17;

  // Bit of the line status byte that flags a break.
  localparam int unsigned BREAK_POS = 4;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_ESCAPE_CHAR   = 3'd0;
  localparam logic [2:0] REG_PARSE_ENABLE  = 3'd1;
  localparam logic [2:0] REG_LSR_MASK      = 3'd2;
  localparam logic [2:0] REG_MSR_MASK      = 3'd3;
  localparam logic [2:0] REG_REPORT_BREAK  = 3'd4;
  localparam logic [2:0] REG_REPORT_BAUD   = 3'd5;
  localparam logic [2:0] REG_REPORT_LCTL   = 3'd6;

  localparam int unsigned MAX_RESULTS = 3;

  typedef struct packed {
    logic [7:0] escape_char;
    logic       parse_enable;
    logic [7:0] line_status_mask;
    logic [7:0] modem_status_mask;
    logic       report_break;
    logic       report_baud;
    logic       report_line_control;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic [7:0]  mask;
  } result_t;

  // All results caused by one input byte, in delivery order.
  typedef struct packed {
    logic [1:0]                    count;
    result_t [MAX_RESULTS-1:0]     res;
  } result_set_t;

endpackage

// File: rtl/serial_escape_stream_parser.sv
// ----------------------------------------------------------------------------
// Serial escape stream parser
// Parses an escaped serial receive stream into data bytes and status events.
// ----------------------------------------------------------------------------
// Input beats (in_valid/in_ready) carry one received byte each. Output beats
// (out_valid/out_ready) carry one result: kind, value, mask, and last, which
// marks the final result caused by an input byte. A byte may cause zero to
// three results. Configuration is written through the APB-style port while
// the stream is idle.
// A byte accepted into the input register has its first result on the output
// in the cycle after, when the result register is free. Throughput: one byte
// per cycle while each byte causes at most one result and out_ready is high; a
// byte with several results holds the parser until the single result register,
// which delivers one beat per cycle while out_ready is high, has sent them all.
// Reset clears the parse state and loads the register defaults; no clearing
// pass is needed. When the receiver stalls, the pending result holds, bytes
// without results keep flowing, and in_ready drops once a byte that causes
// results waits in the input register.
// ----------------------------------------------------------------------------
module serial_escape_stream_parser
  import sesp_pkg::*;
#(
  parameter int unsigned BAUD_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  // APB-style configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // Result output
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] value,
  output logic [7:0]  mask,
  output logic        last
);

  cfg_t        cfg;
  result_set_t res_set;
  logic        inreg_valid;
  logic [7:0]  inreg_byte;
  logic        set_free;
  logic        take;
  logic        load;

  sesp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // A byte is parsed when its results have room in the output stage.
  assign take     = inreg_valid && ((res_set.count == 2'd0) || set_free);
  assign load     = take && (res_set.count != 2'd0);
  assign in_ready = !inreg_valid || take;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      inreg_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      inreg_valid <= 1'b1;
    end else if (take) begin
      inreg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      inreg_byte <= in_byte;
    end
  end

  sesp_parser #(
    .BAUD_BYTES (BAUD_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .step    (take),
    .ch      (inreg_byte),
    .res_set (res_set)
  );

  sesp_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (load),
    .set_in    (res_set),
    .free      (set_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .value     (value),
    .mask      (mask),
    .last      (last)
  );

endmodule

// File: rtl/sesp_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style register file holding the escape character, enables and masks.
// ----------------------------------------------------------------------------
module sesp_regs
  import sesp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:2];

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.escape_char         <= 8'hFF;
      cfg.parse_enable        <= 1'b1;
      cfg.line_status_mask    <= 8'h00;
      cfg.modem_status_mask   <= 8'h00;
      cfg.report_break        <= 1'b0;
      cfg.report_baud         <= 1'b0;
      cfg.report_line_control <= 1'b0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ESCAPE_CHAR:  cfg.escape_char         <= pwdata[7:0];
        REG_PARSE_ENABLE: cfg.parse_enable        <= pwdata[0];
        REG_LSR_MASK:     cfg.line_status_mask    <= pwdata[7:0];
        REG_MSR_MASK:     cfg.modem_status_mask   <= pwdata[7:0];
        REG_REPORT_BREAK: cfg.report_break        <= pwdata[0];
        REG_REPORT_BAUD:  cfg.report_baud         <= pwdata[0];
        REG_REPORT_LCTL:  cfg.report_line_control <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    case (reg_idx)
      REG_ESCAPE_CHAR:  prdata = {24'd0, cfg.escape_char};
      REG_PARSE_ENABLE: prdata = {31'd0, cfg.parse_enable};
      REG_LSR_MASK:     prdata = {24'd0, cfg.line_status_mask};
      REG_MSR_MASK:     prdata = {24'd0, cfg.modem_status_mask};
      REG_REPORT_BREAK: prdata = {31'd0, cfg.report_break};
      REG_REPORT_BAUD:  prdata = {31'd0, cfg.report_baud};
      REG_REPORT_LCTL:  prdata = {31'd0, cfg.report_line_control};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/sesp_parser.sv
// ----------------------------------------------------------------------------
// Escape sequence parser
// Holds the sequence state and turns one registered byte into its results.
// ----------------------------------------------------------------------------
`include "serial_escape_stream_parser_defines.svh"

module sesp_parser
  import sesp_pkg::*;
#(
  parameter int unsigned BAUD_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        step,
  input  logic [7:0]  ch,
  output result_set_t res_set
);

  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  seq_code;
  logic [7:0]  seq_code_next;
  logic [2:0]  byte_index;
  logic [2:0]  byte_index_next;
  logic [31:0] collected;
  logic [31:0] collected_next;

  logic [1:0]  cnt;
  logic [7:0]  st;
  logic [31:0] baud_part;
  logic [31:0] lctl_part;
  logic [31:0] coll_new;
  logic        known_code;
  logic        baud_done;

  assign known_code = (ch == CODE_LSR_DATA) || (ch == CODE_LSR_ONLY) || (ch == CODE_MST) ||
                      (ch == CODE_BAUD) || (ch == CODE_LCTL);

  // Byte lanes of the multi-byte sequences.
  assign baud_part = (byte_index < 3'd4) ? ({24'd0, ch} << {byte_index[1:0], 3'b000}) : 32'd0;
  assign lctl_part = (byte_index < 3'd3) ? ({24'd0, ch} << {byte_index[1:0], 3'b000}) : 32'd0;
  assign baud_done = ({1'b0, byte_index} + 4'd1) >= 4'(BAUD_BYTES);

  // Next state and results for the byte at the input register.
  always_comb begin
    phase_next      = phase;
    seq_code_next   = seq_code;
    byte_index_next = byte_index;
    collected_next  = collected;
    res_set         = '0;
    cnt             = 2'd0;
    st              = (byte_index == 3'd0) ? ch : collected[7:0];
    coll_new        = 32'd0;

    if (!cfg.parse_enable) begin
      res_set.res[cnt] = '{KIND_DATA, {24'd0, ch}, 8'd0};
      cnt = cnt + 2'd1;
    end else begin
      case (phase)
        PH_NORMAL: begin
          if (ch == cfg.escape_char) begin
            phase_next = PH_CODE;
          end else begin
            res_set.res[cnt] = '{KIND_DATA, {24'd0, ch}, 8'd0};
            cnt = cnt + 2'd1;
          end
        end
        PH_CODE: begin
          byte_index_next = 3'd0;
          if (ch == CODE_ESC) begin
            res_set.res[cnt] = '{KIND_DATA, {24'd0, cfg.escape_char}, 8'd0};
            cnt = cnt + 2'd1;
            phase_next    = PH_NORMAL;
            seq_code_next = 8'd0;
          end else if (known_code) begin
            phase_next    = PH_COLLECT;
            seq_code_next = ch;
          end else begin
            phase_next    = PH_NORMAL;
            seq_code_next = 8'd0;
          end
        end
        PH_COLLECT: begin
          phase_next      = PH_NORMAL;
          seq_code_next   = 8'd0;
          byte_index_next = 3'd0;
          if ((seq_code == CODE_LSR_DATA) || (seq_code == CODE_LSR_ONLY)) begin
            if (byte_index == 3'd0) begin
              collected_next = {24'd0, ch};
            end
            if ((byte_index == 3'd0) && (seq_code == CODE_LSR_DATA)) begin
              // Status byte taken; the data byte follows.
              phase_next      = PH_COLLECT;
              seq_code_next   = seq_code;
              byte_index_next = 3'd1;
            end else begin
              if (cfg.report_break) begin
                res_set.res[cnt] = '{KIND_BREAK, {31'd0, st[BREAK_POS]}, 8'd0};
                cnt = cnt + 2'd1;
              end
              if ((st & cfg.line_status_mask) != 8'd0) begin
                res_set.res[cnt] = '{KIND_LSR, {24'd0, st}, cfg.line_status_mask};
                cnt = cnt + 2'd1;
              end
              // A zero data byte that goes with a break is dropped.
              if ((byte_index != 3'd0) && (!st[BREAK_POS] || (ch != 8'd0))) begin
                res_set.res[cnt] = '{KIND_DATA, {24'd0, ch}, 8'd0};
                cnt = cnt + 2'd1;
              end
            end
          end else if (seq_code == CODE_MST) begin
            if (cfg.modem_status_mask != 8'd0) begin
              res_set.res[cnt] = '{KIND_MSR, {24'd0, ch}, cfg.modem_status_mask};
              cnt = cnt + 2'd1;
            end
          end else if (seq_code == CODE_BAUD) begin
            coll_new       = (byte_index == 3'd0) ? baud_part : (collected | baud_part);
            collected_next = coll_new;
            if (baud_done) begin
              if (cfg.report_baud) begin
                res_set.res[cnt] = '{KIND_BAUD, coll_new, 8'd0};
                cnt = cnt + 2'd1;
              end
            end else begin
              phase_next      = PH_COLLECT;
              seq_code_next   = seq_code;
              byte_index_next = byte_index + 3'd1;
            end
          end else if (seq_code == CODE_LCTL) begin
            coll_new       = (byte_index == 3'd0) ? lctl_part : (collected | lctl_part);
            collected_next = coll_new;
            if (byte_index >= 3'd2) begin
              if (cfg.report_line_control) begin
                res_set.res[cnt] = '{KIND_LCTL, {8'd0, coll_new[23:0]}, 8'd0};
                cnt = cnt + 2'd1;
              end
            end else begin
              phase_next      = PH_COLLECT;
              seq_code_next   = seq_code;
              byte_index_next = byte_index + 3'd1;
            end
          end
        end
        default: begin
          phase_next      = PH_NORMAL;
          seq_code_next   = 8'd0;
          byte_index_next = 3'd0;
        end
      endcase
    end
    res_set.count = cnt;
  end

  // Sequence state.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_NORMAL;
      seq_code   <= 8'd0;
      byte_index <= 3'd0;
    end else if (step) begin
      phase      <= phase_next;
      seq_code   <= seq_code_next;
      byte_index <= byte_index_next;
    end
  end

  // The collected bytes are always written before they are read.
  always_ff @(posedge clk) begin
    if (step) begin
      collected <= collected_next;
    end
  end

  `SESP_ASSERT_NOW(a_normal_clean, clk, rst, phase == PH_NORMAL,
    (seq_code == 8'd0) && (byte_index == 3'd0), "sequence state left over in normal phase")
  `SESP_ASSERT_NEXT(a_code_one_byte, clk, rst, step && cfg.parse_enable && (phase == PH_CODE),
    phase != PH_CODE, "code phase lasted more than one byte")
  `SESP_ASSERT_NEXT(a_bypass_keeps_state, clk, rst, step && !cfg.parse_enable,
    (phase == $past(phase)) && (byte_index == $past(byte_index)),
    "state changed while parsing was disabled")

endmodule

// File: rtl/sesp_out.sv
// ----------------------------------------------------------------------------
// Result output stage
// Registers the result set of one byte and hands its results out one beat
// at a time.
// ----------------------------------------------------------------------------
`include "serial_escape_stream_parser_defines.svh"

module sesp_out
  import sesp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  result_set_t set_in,
  output logic        free,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  kind,
  output logic [31:0] value,
  output logic [7:0]  mask,
  output logic        last
);

  result_set_t set_q;
  logic        set_valid;
  logic [1:0]  rd_idx;
  logic [1:0]  last_idx;
  logic        fire;
  logic        done;
  result_t     cur;

  assign last_idx  = set_q.count - 2'd1;
  assign cur       = set_q.res[rd_idx];
  assign out_valid = set_valid;
  assign kind      = cur.kind;
  assign value     = cur.value;
  assign mask      = cur.mask;
  assign last      = (rd_idx == last_idx);
  assign fire      = set_valid && out_ready;
  assign done      = fire && last;
  assign free      = !set_valid || done;

  // Result set payload.
  always_ff @(posedge clk) begin
    if (load) begin
      set_q <= set_in;
    end
  end

  // Beat sequencing over the stored results.
  always_ff @(posedge clk) begin
    if (rst) begin
      set_valid <= 1'b0;
      rd_idx    <= 2'd0;
    end else if (load) begin
      set_valid <= 1'b1;
      rd_idx    <= 2'd0;
    end else if (done) begin
      set_valid <= 1'b0;
      rd_idx    <= 2'd0;
    end else if (fire) begin
      rd_idx <= rd_idx + 2'd1;
    end
  end

  `SESP_ASSERT_NOW(a_idx_in_range, clk, rst, set_valid, rd_idx <= last_idx,
    "read index ran past the last result")
  `SESP_ASSERT_NOW(a_load_when_free, clk, rst, load, free && (set_in.count != 2'd0),
    "result set loaded over a pending one or empty")
  `SESP_ASSERT_NEXT(a_load_restarts, clk, rst, load, set_valid && (rd_idx == 2'd0),
    "new result set did not start at its first result")

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// Serial escape stream parser testbench
// Drives escaped byte streams into the parser under several register
// settings. A scoreboard predicts the data and status beats that each
// accepted byte should cause and checks every output beat against them.
// Both sides insert random idle cycles.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sesp_pkg::*;

  localparam int unsigned BAUD_BYTES = 4;
  // Index with no register behind it; writes there must be ignored.
  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_BYTES = 45;
  localparam int DRAIN_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 10;

  typedef struct {
    kind_t       kind;
    logic [31:0] value;
    logic [7:0]  mask;
    logic        last;
  } parsed_event_t;

  // Predicts parser output and checks the beats that come out.
  class escape_parse_scoreboard;
    logic [7:0]  escape_char = 8'hFF;
    logic        parse_enable = 1'b1;
    logic [7:0]  line_status_mask = 8'h00;
    logic [7:0]  modem_status_mask = 8'h00;
    logic        report_break = 1'b0;
    logic        report_baud = 1'b0;
    logic        report_line_control = 1'b0;

    phase_t      ph = PH_NORMAL;
    logic [7:0]  seq_code = 8'h00;
    logic [2:0]  byte_pos = 3'd0;
    logic [31:0] collected = 32'h0;

    parsed_event_t batch[$];
    parsed_event_t expected[$];
    int errors = 0;
    int bytes_seen = 0;
    int results_checked = 0;

    function void write_reg(logic [2:0] idx, logic [31:0] d);
      case (idx)
        REG_ESCAPE_CHAR:  escape_char = d[7:0];
        REG_PARSE_ENABLE: parse_enable = d[0];
        REG_LSR_MASK:     line_status_mask = d[7:0];
        REG_MSR_MASK:     modem_status_mask = d[7:0];
        REG_REPORT_BREAK: report_break = d[0];
        REG_REPORT_BAUD:  report_baud = d[0];
        REG_REPORT_LCTL:  report_line_control = d[0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(logic [2:0] idx);
      case (idx)
        REG_ESCAPE_CHAR:  return {24'd0, escape_char};
        REG_PARSE_ENABLE: return {31'd0, parse_enable};
        REG_LSR_MASK:     return {24'd0, line_status_mask};
        REG_MSR_MASK:     return {24'd0, modem_status_mask};
        REG_REPORT_BREAK: return {31'd0, report_break};
        REG_REPORT_BAUD:  return {31'd0, report_baud};
        REG_REPORT_LCTL:  return {31'd0, report_line_control};
        default:          return 32'd0;
      endcase
    endfunction

    function void emit(kind_t k, logic [31:0] v, logic [7:0] m);
      parsed_event_t e;
      e.kind = k;
      e.value = v;
      e.mask = m;
      e.last = 1'b0;
      batch.push_back(e);
    endfunction

    function void back_to_normal();
      ph = PH_NORMAL;
      seq_code = 8'h00;
      byte_pos = 3'd0;
    endfunction

    // Advance the parse state by one accepted byte and queue its results.
    function void note_byte(logic [7:0] ch);
      logic [2:0]  pos;
      logic [7:0]  st;
      logic [31:0] part;
      bit          done;
      bit          with_data;
      batch.delete();
      bytes_seen++;
      pos = byte_pos;
      done = 1'b0;
      with_data = 1'b0;
      if (!parse_enable) begin
        emit(KIND_DATA, {24'd0, ch}, 8'd0);
      end else if (ph == PH_NORMAL) begin
        if (ch == escape_char) ph = PH_CODE;
        else emit(KIND_DATA, {24'd0, ch}, 8'd0);
      end else if (ph == PH_CODE) begin
        seq_code = ch;
        byte_pos = 3'd0;
        if (ch == CODE_ESC) begin
          emit(KIND_DATA, {24'd0, escape_char}, 8'd0);
          back_to_normal();
        end else if (ch inside {CODE_LSR_DATA, CODE_LSR_ONLY, CODE_MST, CODE_BAUD,
                                CODE_LCTL}) begin
          ph = PH_COLLECT;
        end else begin
          back_to_normal();
        end
      end else begin
        case (seq_code)
          CODE_LSR_DATA, CODE_LSR_ONLY: begin
            if (pos == 3'd0) begin
              collected = {24'd0, ch};
              if (seq_code == CODE_LSR_DATA) byte_pos = 3'd1;
              else done = 1'b1;
            end else begin
              done = 1'b1;
              with_data = 1'b1;
            end
            if (done) begin
              st = collected[7:0];
              if (report_break) emit(KIND_BREAK, {31'd0, st[BREAK_POS]}, 8'd0);
              if ((st & line_status_mask) != 8'd0)
                emit(KIND_LSR, {24'd0, st}, line_status_mask);
              // A zero data byte that follows a break is dropped.
              if (with_data && (!st[BREAK_POS] || ch != 8'd0))
                emit(KIND_DATA, {24'd0, ch}, 8'd0);
              back_to_normal();
            end
          end
          CODE_MST: begin
            if (modem_status_mask != 8'd0) emit(KIND_MSR, {24'd0, ch}, modem_status_mask);
            back_to_normal();
          end
          CODE_BAUD: begin
            part = (pos < 3'd4) ? ({24'd0, ch} << (8 * pos)) : 32'd0;
            collected = (pos == 3'd0) ? part : (collected | part);
            if (int'(pos) + 1 >= BAUD_BYTES) begin
              if (report_baud) emit(KIND_BAUD, collected, 8'd0);
              back_to_normal();
            end else begin
              byte_pos = pos + 3'd1;
            end
          end
          CODE_LCTL: begin
            part = (pos < 3'd3) ? ({24'd0, ch} << (8 * pos)) : 32'd0;
            collected = (pos == 3'd0) ? part : (collected | part);
            if (pos >= 3'd2) begin
              if (report_line_control) emit(KIND_LCTL, collected & 32'h00FF_FFFF, 8'd0);
              back_to_normal();
            end else begin
              byte_pos = pos + 3'd1;
            end
          end
          default: back_to_normal();
        endcase
      end
      if (batch.size() > 0) batch[$].last = 1'b1;
      foreach (batch[i]) expected.push_back(batch[i]);
    endfunction

    // Compare one output beat with the oldest prediction.
    function void check_result(logic [2:0] k, logic [31:0] v, logic [7:0] m, logic l);
      parsed_event_t e;
      results_checked++;
      if (expected.size() == 0) begin
        $error("unexpected result beat: kind %0d value %0h mask %0h last %0b", k, v, m, l);
        errors++;
        return;
      end
      e = expected.pop_front();
      if (k !== e.kind) begin
        $error("kind: expected %0d, actual %0d", e.kind, k);
        errors++;
      end
      if (v !== e.value) begin
        $error("value: expected %0h, actual %0h", e.value, v);
        errors++;
      end
      if (m !== e.mask) begin
        $error("mask: expected %0h, actual %0h", e.mask, m);
        errors++;
      end
      if (l !== e.last) begin
        $error("last: expected %0b, actual %0b", e.last, l);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  kind;
  logic [31:0] value;
  logic [7:0]  mask;
  logic        last;

  escape_parse_scoreboard sb;
  logic [7:0] stim[$];
  int in_gap_pct;
  int out_stall_pct;
  int settings_applied;

  serial_escape_stream_parser #(.BAUD_BYTES(BAUD_BYTES)) dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .value(value), .mask(mask), .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard limit on the whole run.
  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  // Output side: back-pressure in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready = 1'b0;
      end else if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        stall_left = pick_gap(out_stall_pct);
      end
    end
  end

  // Every output beat is checked at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(kind, value, mask, last);
  end

  // Write one register and, unless it is the unused index, read it back.
  task automatic set_reg(logic [2:0] idx, logic [31:0] d);
    logic [31:0] width_mask;
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = d;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, d);
    @(negedge clk);
    penable = 1'b0;
    pwrite = 1'b0;
    if (idx != REG_UNUSED) begin
      case (idx)
        REG_ESCAPE_CHAR, REG_LSR_MASK, REG_MSR_MASK: width_mask = 32'hFF;
        default: width_mask = 32'h1;
      endcase
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      if ((prdata & width_mask) !== sb.reg_value(idx)) begin
        $error("register %0d: expected %0h, actual %0h", idx, sb.reg_value(idx), prdata);
        sb.errors++;
      end
      @(negedge clk);
      penable = 1'b0;
    end
    psel = 1'b0;
  endtask

  task automatic apply_settings(logic [7:0] esc, logic en, logic [7:0] lsm, logic [7:0] msm,
                                logic rb, logic rbaud, logic rlc);
    set_reg(REG_ESCAPE_CHAR, {24'd0, esc});
    set_reg(REG_PARSE_ENABLE, {31'd0, en});
    set_reg(REG_LSR_MASK, {24'd0, lsm});
    set_reg(REG_MSR_MASK, {24'd0, msm});
    set_reg(REG_REPORT_BREAK, {31'd0, rb});
    set_reg(REG_REPORT_BAUD, {31'd0, rbaud});
    set_reg(REG_REPORT_LCTL, {31'd0, rlc});
    settings_applied++;
  endtask

  // Send every byte of the stimulus queue, one beat each, with random gaps.
  task automatic send_stream();
    int gap;
    foreach (stim[i]) begin
      gap = pick_gap(in_gap_pct);
      if (gap > 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      @(negedge clk);
      in_valid = 1'b1;
      in_byte = stim[i];
      do @(posedge clk); while (!in_ready);
      sb.note_byte(stim[i]);
    end
    @(negedge clk);
    in_valid = 1'b0;
    stim.delete();
  endtask

  // Wait for every predicted beat, then let bytes without results settle.
  task automatic wait_until_idle();
    int waited;
    waited = 0;
    while (sb.expected.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (sb.expected.size() > 0) begin
      $error("%0d predicted result beats never arrived", sb.expected.size());
      sb.errors++;
      sb.expected.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly well-formed escape sequences with random content, some noise.
  task automatic build_random_stream(int n);
    logic [7:0] e;
    logic [7:0] b;
    int pick;
    e = sb.escape_char;
    while (stim.size() < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        b = 8'($urandom);
        if (b == e) b = ~e;
        stim.push_back(b);
      end else if (pick < 40) begin
        stim.push_back(e);
        stim.push_back(CODE_ESC);
      end else if (pick < 55) begin
        // Status with break half the time, data zero a quarter of the time.
        b = 8'($urandom);
        b[BREAK_POS] = $urandom_range(0, 1);
        stim.push_back(e);
        stim.push_back(CODE_LSR_DATA);
        stim.push_back(b);
        stim.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
      end else if (pick < 63) begin
        stim.push_back(e);
        stim.push_back(CODE_LSR_ONLY);
        stim.push_back(8'($urandom));
      end else if (pick < 71) begin
        stim.push_back(e);
        stim.push_back(CODE_MST);
        stim.push_back(8'($urandom));
      end else if (pick < 79) begin
        stim.push_back(e);
        stim.push_back(CODE_BAUD);
        repeat (BAUD_BYTES) stim.push_back(8'($urandom));
      end else if (pick < 87) begin
        stim.push_back(e);
        stim.push_back(CODE_LCTL);
        repeat (3) stim.push_back(8'($urandom));
      end else if (pick < 92) begin
        b = 8'($urandom);
        if (b inside {CODE_ESC, CODE_LSR_DATA, CODE_LSR_ONLY, CODE_MST, CODE_BAUD, CODE_LCTL})
          b = b | 8'h80;
        stim.push_back(e);
        stim.push_back(b);
      end else if (pick < 96) begin
        // Sequence cut short: the following bytes land in its body.
        stim.push_back(e);
        case ($urandom_range(0, 4))
          0: stim.push_back(CODE_LSR_DATA);
          1: stim.push_back(CODE_LSR_ONLY);
          2: stim.push_back(CODE_MST);
          3: stim.push_back(CODE_BAUD);
          default: stim.push_back(CODE_LCTL);
        endcase
      end else begin
        stim.push_back(8'($urandom));
      end
    end
  endtask

  initial begin
    logic [7:0] esc;
    logic       en;
    logic [7:0] lsm;
    logic [7:0] msm;
    sb = new();
    settings_applied = 0;
    in_gap_pct = 30;
    out_stall_pct = 30;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset defaults: most events are suppressed.
    build_random_stream(40);
    send_stream();
    wait_until_idle();

    // Directed: one of each sequence with every event enabled. The line
    // status mask leaves out the break bit so a bare break is not reported
    // as line status.
    apply_settings(8'hFF, 1'b1, 8'hEF, 8'hFF, 1'b1, 1'b1, 1'b1);
    stim = '{8'h00,
             8'hFF, CODE_ESC,
             8'hFF, CODE_LSR_DATA, 8'h10, 8'h00,
             8'hFF, CODE_LSR_DATA, 8'hFF, 8'h55,
             8'hFF, CODE_LSR_ONLY, 8'hEF,
             8'hFF, CODE_MST, 8'hA5,
             8'hFF, CODE_BAUD, 8'h78, 8'h56, 8'h34, 8'h12,
             8'hFF, CODE_LCTL, 8'h08, 8'h02, 8'h01,
             8'hFF, 8'h42};
    send_stream();
    wait_until_idle();
    set_reg(REG_UNUSED, 32'hFFFF_FFFF);

    // Random phases under varied settings and idle patterns.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 0) begin
        in_gap_pct = 0;
        out_stall_pct = 0;
        apply_settings(8'h00, 1'b1, 8'hFF, 8'hFF, 1'b1, 1'b1, 1'b1);
      end else begin
        case ($urandom_range(0, 2))
          0: in_gap_pct = 10;
          1: in_gap_pct = 30;
          default: in_gap_pct = 60;
        endcase
        case ($urandom_range(0, 2))
          0: out_stall_pct = 10;
          1: out_stall_pct = 30;
          default: out_stall_pct = 60;
        endcase
        if (p == 1) begin
          apply_settings(8'hFF, 1'b1, 8'h00, 8'h00, 1'b0, 1'b0, 1'b0);
        end else begin
          esc = 8'($urandom);
          en = (p == 2) ? 1'b0 : ($urandom_range(0, 4) != 0);
          lsm = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
          msm = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
          apply_settings(esc, en, lsm, msm, 1'($urandom), 1'($urandom), 1'($urandom));
        end
      end
      build_random_stream(PHASE_BYTES);
      send_stream();
      wait_until_idle();
    end

    $display("Sent %0d input beats and checked %0d result beats under %0d register settings.",
             sb.bytes_seen, sb.results_checked, settings_applied);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
